>>> design/aim_basis_matrix_builder_core_defines.svh
// Assertion macros for the aim basis matrix builder.
// Used by the top level; no other dependencies.
`ifndef AIM_BASIS_MATRIX_BUILDER_CORE_DEFINES_SVH
`define AIM_BASIS_MATRIX_BUILDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ABM_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ABM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ABM_ASSERT_IMPL(label, clk, rst_n, prop)
`define ABM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> design/abm_pkg.sv
// Package for the aim basis matrix builder: payload types and fixed-point helpers.
// No dependencies.
package abm_pkg;
    localparam int FracBitsDefault = 16;

    typedef enum logic [1:0] {
        COL_SIDE = 2'd0,
        COL_UP   = 2'd1,
        COL_AIM  = 2'd2,
        COL_ORG  = 2'd3
    } t_col;

    typedef struct packed {
        logic signed [31:0] aim_x;
        logic signed [31:0] aim_y;
        logic signed [31:0] aim_z;
        logic signed [31:0] up_hint_x;
        logic signed [31:0] up_hint_y;
        logic signed [31:0] up_hint_z;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] axis_scale;
    } t_req;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] col_x;
        logic signed [31:0] col_y;
        logic signed [31:0] col_z;
        logic               homogeneous_one;
        logic               last_column;
        logic               degenerate;
    } t_res;

    // Clamp a 66-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction
endpackage

>>> design/abm_sqrt.sv
// Pipelined integer square root, two result bits per stage.
// Depends on abm_pkg.
module abm_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [65:0] i_x,
    output logic        o_vld,
    output logic [32:0] o_root
);
    import abm_pkg::*;
    localparam int Stages = 17;
    localparam int BitsPerStage = 2;

    logic [65:0] r_rem  [Stages+1];
    logic [32:0] r_root [Stages+1];
    logic [Stages:0] r_vld;

    always_comb begin
        r_rem[0]  = i_x;
        r_root[0] = '0;
    end
    assign r_vld[0] = i_vld;

    // Each stage resolves two root bits by restoring subtraction.
    // The first bit tried sits above the root range and always resolves to zero.
    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic [65:0] n_rem;
        logic [32:0] n_root;
        always_comb begin
            logic [65:0] rem;
            logic [32:0] root;
            logic [67:0] trial;
            rem  = r_rem[s];
            root = r_root[s];
            for (int b = 0; b < BitsPerStage; b++) begin
                trial = 68'({2'b0, root, 2'b01}) << (2 * (33 - (s * BitsPerStage + b)));
                if ({2'b0, rem} >= trial) begin
                    rem  = rem - trial[65:0];
                    root = {root[31:0], 1'b1};
                end else begin
                    root = {root[31:0], 1'b0};
                end
            end
            n_rem  = rem;
            n_root = root;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1]  <= n_rem;
            r_root[s+1] <= n_root;
        end
    end
    assign o_vld  = r_vld[Stages];
    assign o_root = r_root[Stages];
endmodule

>>> design/abm_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on abm_pkg.
module abm_div #(
    parameter int FRAC_BITS = abm_pkg::FracBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [31:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_vld,
    output logic [32:0] o_quo
);
    import abm_pkg::*;
    localparam int Nb   = 32 + FRAC_BITS;
    localparam int Qb   = 33;
    localparam int TopB = Nb - Qb;

    logic [Nb-1:0] r_num [Qb+1];
    logic [32:0]   r_den [Qb+1];
    logic [32:0]   r_rem [Qb+1];
    logic [Qb-1:0] r_quo [Qb+1];
    logic [Qb:0]   r_sat;
    logic [Qb:0]   r_vld;

    // Numerator bits above the quotient range seed the remainder; if they
    // already reach the divisor, the quotient overflows and is saturated.
    logic [Nb-1:0]   w_num;
    logic [TopB-1:0] w_top;
    assign w_num = {i_num, {FRAC_BITS{1'b0}}};
    assign w_top = w_num[Nb-1:Qb];

    always_comb begin
        r_num[0] = w_num;
        r_den[0] = i_den;
        r_rem[0] = 33'(w_top);
        r_quo[0] = '0;
    end
    assign r_sat[0] = (33'(w_top) >= i_den);
    assign r_vld[0] = i_vld;

    // Each stage brings down one numerator bit and resolves one quotient bit.
    for (genvar s = 0; s < Qb; s++) begin : g_stage
        logic [33:0]   w_t;
        logic [32:0]   n_rem;
        logic [Qb-1:0] n_quo;
        assign w_t = {r_rem[s], r_num[s][Qb-1-s]};
        always_comb begin
            if (w_t >= {1'b0, r_den[s]}) begin
                n_rem = 33'(w_t - {1'b0, r_den[s]});
                n_quo = {r_quo[s][Qb-2:0], 1'b1};
            end else begin
                n_rem = w_t[32:0];
                n_quo = {r_quo[s][Qb-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_num[s+1] <= r_num[s];
            r_den[s+1] <= r_den[s];
            r_rem[s+1] <= n_rem;
            r_quo[s+1] <= n_quo;
            r_sat[s+1] <= r_sat[s];
        end
    end
    assign o_vld = r_vld[Qb];
    assign o_quo = r_sat[Qb] ? {Qb{1'b1}} : r_quo[Qb];
endmodule

>>> design/aim_basis_matrix_builder_core.sv
// Top level of the aim basis matrix builder: front math, sqrt, divide, back math, column sequencer.
// Depends on abm_pkg, abm_sqrt, abm_div and the defines header.
//
// Channel   Direction  Handshake                 Payload
// request   in         i_start & !o_busy         i_req (t_req)
// result    out        o_strobe (no backpressure) o_res (t_res)
//
// After each accepted request, o_busy holds off the next one until the gap counter runs down;
// the four columns leave on consecutive cycles, so the column sequencer sets the rate.
// Path of a request: stages 1-4, square root, dividers, stages 5-7, output register.
// Reset is synchronous and clears all valid bits; payload is not reset.
// The receiver cannot stall, so the pipelines never hold.
`include "aim_basis_matrix_builder_core_defines.svh"
module aim_basis_matrix_builder_core #(
    parameter int FRAC_BITS = abm_pkg::FracBitsDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  abm_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_strobe,
    output abm_pkg::t_res o_res
);
    import abm_pkg::*;
    localparam int SqLat  = 17;
    localparam int DivLat = 33;
    localparam int DlyLen = SqLat + DivLat;

    typedef logic signed [31:0] t_v3 [3];

    function automatic logic signed [63:0] fm(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    // Intake pacing: o_busy stays high after each accepted request until the gap counter runs down.
    logic [1:0] r_gap;
    logic       w_acc;
    assign o_busy = (r_gap != 2'd0);
    assign w_acc  = i_start && !o_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else if (w_acc) begin
            r_gap <= 2'd3;
        end else if (r_gap != 2'd0) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    // Stage 1: register request.
    t_req r1_req;
    logic r1_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_acc;
        end
        r1_req <= i_req;
    end

    // Stage 2: dot product.
    t_req r2_req;
    logic r2_vld;
    logic signed [31:0] r2_dot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_req <= r1_req;
        r2_dot <= sat32(66'(fm(r1_req.aim_x, r1_req.up_hint_x))
                      + 66'(fm(r1_req.aim_y, r1_req.up_hint_y))
                      + 66'(fm(r1_req.aim_z, r1_req.up_hint_z)));
    end

    // Stage 3: orthogonal up.
    t_req r3_req;
    logic r3_vld;
    t_v3  r3_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_req  <= r2_req;
        r3_n[0] <= sat32(66'(r2_req.up_hint_x) - 66'(fm(r2_req.aim_x, r2_dot)));
        r3_n[1] <= sat32(66'(r2_req.up_hint_y) - 66'(fm(r2_req.aim_y, r2_dot)));
        r3_n[2] <= sat32(66'(r2_req.up_hint_z) - 66'(fm(r2_req.aim_z, r2_dot)));
    end

    // Stage 4: squared length (the sum of three squares fits in 64 bits).
    t_req r4_req;
    logic r4_vld;
    t_v3  r4_n;
    logic [63:0] r4_sq [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_req <= r3_req;
        r4_n   <= r3_n;
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= 64'($signed(64'(r3_n[i])) * $signed(64'(r3_n[i])));
        end
    end
    logic [63:0] w_sum;
    assign w_sum = r4_sq[0] + r4_sq[1] + r4_sq[2];

    logic        sq_vld;
    logic [32:0] sq_root;
    abm_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_vld(r4_vld), .i_x({2'b0, w_sum}),
        .o_vld(sq_vld), .o_root(sq_root)
    );

    // Carry the request alongside the square root and divider, and the orthogonal up alongside the square root.
    t_req r_dreq [DlyLen+1];
    t_v3  r_dn   [SqLat+1];
    always_comb begin
        r_dreq[0] = r4_req;
        r_dn[0]   = r4_n;
    end
    for (genvar k = 0; k < DlyLen; k++) begin : g_dreq
        always_ff @(posedge i_clk) r_dreq[k+1] <= r_dreq[k];
    end
    for (genvar k = 0; k < SqLat; k++) begin : g_dn
        always_ff @(posedge i_clk) r_dn[k+1] <= r_dn[k];
    end

    logic [2:0]  dv_vld;
    logic [32:0] dv_q [3];
    logic [32:0] w_den;
    assign w_den = (sq_root == '0) ? 33'd1 : sq_root;
    logic [2:0] w_neg;
    logic [31:0] w_mag [3];
    for (genvar i = 0; i < 3; i++) begin : g_div
        assign w_neg[i] = r_dn[SqLat][i][31];
        assign w_mag[i] = w_neg[i] ? 32'(-r_dn[SqLat][i]) : r_dn[SqLat][i];
        abm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk, .i_rst_n, .i_vld(sq_vld), .i_num(w_mag[i]), .i_den(w_den),
            .o_vld(dv_vld[i]), .o_quo(dv_q[i])
        );
    end

    // Sign and degenerate flag travel with the divider.
    logic [2:0] r_dsgn [DivLat+1];
    logic       r_ddeg [DivLat+1];
    always_comb begin
        r_dsgn[0] = w_neg;
        r_ddeg[0] = (sq_root == '0);
    end
    for (genvar k = 0; k < DivLat; k++) begin : g_ds
        always_ff @(posedge i_clk) begin
            r_dsgn[k+1] <= r_dsgn[k];
            r_ddeg[k+1] <= r_ddeg[k];
        end
    end

    // Stage 5: unit up with sign and saturation, zero when degenerate.
    t_req r5_req;
    logic r5_vld, r5_deg;
    t_v3  r5_u;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= dv_vld[0];
        end
        r5_req <= r_dreq[DlyLen];
        r5_deg <= r_ddeg[DivLat];
        for (int i = 0; i < 3; i++) begin
            logic [32:0] q;
            q = (dv_q[i] > 33'h080000000) ? 33'h080000000 : dv_q[i];
            if (r_ddeg[DivLat])
                r5_u[i] <= '0;
            else
                r5_u[i] <= sat32(r_dsgn[DivLat][i] ? -66'(q) : 66'(q));
        end
    end

    // Stage 6: side axis.
    t_req r6_req;
    logic r6_vld, r6_deg;
    t_v3  r6_u, r6_s;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_req <= r5_req;
        r6_deg <= r5_deg;
        r6_u   <= r5_u;
        r6_s[0] <= sat32(66'(fm(r5_u[1], r5_req.aim_z)) - 66'(fm(r5_u[2], r5_req.aim_y)));
        r6_s[1] <= sat32(66'(fm(r5_u[2], r5_req.aim_x)) - 66'(fm(r5_u[0], r5_req.aim_z)));
        r6_s[2] <= sat32(66'(fm(r5_u[0], r5_req.aim_y)) - 66'(fm(r5_u[1], r5_req.aim_x)));
    end

    // Stage 7: column sequencer, one column per cycle while running.
    t_req r7_req;
    t_v3  r7_u, r7_s;
    logic r7_deg;
    logic [1:0] r_col;
    logic       r_run;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_col <= 2'd0;
        end else if (r6_vld) begin
            r_run <= 1'b1;
            r_col <= 2'd0;
        end else if (r_run) begin
            r_col <= r_col + 2'd1;
            r_run <= (r_col != 2'd3);
        end
        if (r6_vld) begin
            r7_req <= r6_req;
            r7_u   <= r6_u;
            r7_s   <= r6_s;
            r7_deg <= r6_deg;
        end
    end

    // Output register; the last column of one request may leave on the edge
    // that loads the next request into the sequencer.
    t_v3 w_ax;
    always_comb begin
        case (t_col'(r_col))
            COL_SIDE: w_ax = r7_s;
            COL_UP:   w_ax = r7_u;
            default:  w_ax = '{r7_req.aim_x, r7_req.aim_y, r7_req.aim_z};
        endcase
    end
    logic r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_run;
        end
        o_res.column_index    <= r_col;
        o_res.homogeneous_one <= (t_col'(r_col) == COL_ORG);
        o_res.last_column     <= (t_col'(r_col) == COL_ORG);
        o_res.degenerate      <= r7_deg;
        if (t_col'(r_col) == COL_ORG) begin
            o_res.col_x <= r7_req.origin_x;
            o_res.col_y <= r7_req.origin_y;
            o_res.col_z <= r7_req.origin_z;
        end else begin
            o_res.col_x <= sat32(66'(fm(w_ax[0], r7_req.axis_scale)));
            o_res.col_y <= sat32(66'(fm(w_ax[1], r7_req.axis_scale)));
            o_res.col_z <= sat32(66'(fm(w_ax[2], r7_req.axis_scale)));
        end
    end
    assign o_strobe = r_out_vld;

    `ABM_ASSERT_NEXT(a_gap, i_clk, i_rst_n, w_acc, o_busy)
    `ABM_ASSERT_NEXT(a_last, i_clk, i_rst_n, o_strobe && o_res.last_column, !o_strobe || o_res.column_index == 2'd0)
    `ABM_ASSERT_IMPL(a_hom, i_clk, i_rst_n, o_strobe |-> (o_res.homogeneous_one == o_res.last_column))
endmodule
